// ----- hw/rtl/ssc_pkg.sv -----
// Shared types, constants and helpers for the spaced sample collector.
// Used by the lane, control, top-level and checker files; depends on nothing.

package ssc_pkg;

   localparam int LANES       = 4;
   localparam int STORE_DEPTH = 256;
   localparam int SAMPLE_BITS = 16;

   localparam int PORT_LANES = 4;
   localparam int AXES       = 3;
   localparam int SLOT_W     = 16;
   localparam int VEC_W      = AXES * SLOT_W;
   localparam int DIFF_W     = SLOT_W + 1;
   localparam int SQ_W       = 2 * SLOT_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ADDR_W     = $clog2(STORE_DEPTH);
   localparam int FILL_W     = 9;
   localparam int DIST_W     = 32;
   localparam int PPS_W      = 9;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;

   // compare pipeline depth after the last scan address
   localparam int DRAIN_CYCLES = 3;
   localparam int DRAIN_W      = 2;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SIDE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPS      = 2'd1;

   localparam logic [DIST_W-1:0] MIN_DIST_RESET = 32'd10000;
   localparam logic [PPS_W-1:0]  PPS_RESET      = 9'd40;

   // request tdata layout
   localparam int REQ_UPD_LSB  = PORT_LANES * VEC_W;
   localparam int REQ_PRES_LSB = REQ_UPD_LSB + PORT_LANES;
   localparam int REQ_DATA_W   = REQ_PRES_LSB + PORT_LANES;

   // response tdata layout
   localparam int RSP_ACC_BIT    = 0;
   localparam int RSP_REJ_LSB    = 1;
   localparam int RSP_FULL_BIT   = RSP_REJ_LSB + PORT_LANES;
   localparam int RSP_SIDE_LSB   = RSP_FULL_BIT + 1;
   localparam int RSP_DONE_BIT   = RSP_SIDE_LSB + FILL_W;
   localparam int RSP_COUNT_LSB  = RSP_DONE_BIT + 1;
   localparam int RSP_FIELDS_W   = RSP_COUNT_LSB + PORT_LANES * FILL_W;
   localparam int RSP_DATA_W     = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef logic [VEC_W-1:0] vec_type;

   typedef struct packed {
      logic              start;     // new item: drop the sticky reject
      logic              scan_vld;
      logic [ADDR_W-1:0] scan_addr;
      logic              commit;    // set accepted: present lanes append
      logic              clear;     // empty the store
   } lane_cmd_type;

   typedef struct packed {
      logic [FILL_W-1:0] fill;
      logic              reject;
   } lane_stat_type;

   // one axis of a packed vector, sign-extended from bit SAMPLE_BITS-1 of its slot
   function automatic logic signed [DIFF_W-1:0] axis_value(input vec_type v,
                                                           input logic [1:0] axis);
      logic [SLOT_W-1:0] slot;
      slot = v[axis*SLOT_W +: SLOT_W];
      return $signed({{(DIFF_W-SAMPLE_BITS){slot[SAMPLE_BITS-1]}},
                      slot[SAMPLE_BITS-1:0]});
   endfunction

endpackage

// ----- hw/rtl/ssc_lane.sv -----
// One lane of the collector: point store, fill count and the spacing compare pipeline.
// Depends on ssc_pkg.

module ssc_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  ssc_pkg::lane_cmd_type        cmd,
   input  ssc_pkg::vec_type             vec,
   input  logic                         upd,
   input  logic                         pres,
   input  logic [ssc_pkg::DIST_W-1:0]   min_dist,
   output ssc_pkg::lane_stat_type       stat
);

   ssc_pkg::vec_type                 mem [ssc_pkg::STORE_DEPTH];
   ssc_pkg::vec_type                 rd_data_ff;
   logic [ssc_pkg::FILL_W-1:0]       fill_ff, fill_in;
   logic                             s1_vld_ff, s1_vld_in;
   logic                             s2_vld_ff;
   logic                             s3_vld_ff;
   logic [ssc_pkg::SLOT_W-1:0]       abs_ff [ssc_pkg::AXES];
   logic [ssc_pkg::SLOT_W-1:0]       abs_in [ssc_pkg::AXES];
   logic [ssc_pkg::SQ_W-1:0]         sq_ff  [ssc_pkg::AXES];
   logic [ssc_pkg::SUM_W-1:0]        sum;
   logic                             reject_ff, reject_in;
   logic                             append;

   assign append = cmd.commit & pres;

   // store: one write on append, one registered read per scan step
   always_ff @(posedge clock) begin
      if (append) begin
         mem[fill_ff[ssc_pkg::ADDR_W-1:0]] <= upd ? vec : '0;
      end
      if (cmd.scan_vld) begin
         rd_data_ff <= mem[cmd.scan_addr];
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (append) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // only entries below the fill take part, and only for a fresh sample
   assign s1_vld_in = cmd.scan_vld & upd &
                      ({1'b0, cmd.scan_addr} < fill_ff);

   always_comb begin
      logic signed [ssc_pkg::DIFF_W-1:0] d;
      logic signed [ssc_pkg::DIFF_W-1:0] m;
      for (int a = 0; a < ssc_pkg::AXES; a++) begin
         d = ssc_pkg::axis_value(vec, 2'(a)) - ssc_pkg::axis_value(rd_data_ff, 2'(a));
         m = d[ssc_pkg::DIFF_W-1] ? -d : d;
         abs_in[a] = m[ssc_pkg::SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < ssc_pkg::AXES; a++) begin
         abs_ff[a] <= abs_in[a];
         sq_ff[a]  <= ssc_pkg::SQ_W'(abs_ff[a]) * ssc_pkg::SQ_W'(abs_ff[a]);
      end
   end

   assign sum = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};

   always_comb begin
      reject_in = reject_ff;
      if (cmd.start) begin
         reject_in = 1'b0;
      end else if (s3_vld_ff && (sum < {2'b00, min_dist})) begin
         reject_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         reject_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         reject_ff <= reject_in;
      end
   end

   assign stat.fill   = fill_ff;
   assign stat.reject = reject_ff;

endmodule

// ----- hw/rtl/ssc_ctrl.sv -----
// Sequencer and merge stage: item capture, scan control, accept decision, side count,
// configuration registers and the result register. Depends on ssc_pkg.

module ssc_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [ssc_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssc_pkg::DIST_W-1:0]        csr_data,
   output ssc_pkg::lane_cmd_type             cmd,
   output ssc_pkg::vec_type                  lane_vec [ssc_pkg::LANES],
   output logic [ssc_pkg::LANES-1:0]         lane_upd,
   output logic [ssc_pkg::LANES-1:0]         lane_pres,
   output logic [ssc_pkg::DIST_W-1:0]        min_dist,
   input  ssc_pkg::lane_stat_type            lane_stat [ssc_pkg::LANES]
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_DECIDE = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [ssc_pkg::ADDR_W-1:0]         addr_ff, addr_in;
   logic [ssc_pkg::DRAIN_W-1:0]        drain_ff, drain_in;
   logic [ssc_pkg::KIND_W-1:0]         kind_ff;
   ssc_pkg::vec_type                   vec_ff [ssc_pkg::LANES];
   logic [ssc_pkg::LANES-1:0]          upd_ff, pres_ff;
   logic                               do_set_ff, do_set_in;
   logic [ssc_pkg::FILL_W-1:0]         side_ff, side_in;
   logic [ssc_pkg::DIST_W-1:0]         min_dist_ff;
   logic [ssc_pkg::PPS_W-1:0]          pps_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ssc_pkg::RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                               req_xfer, fire;
   logic [ssc_pkg::PORT_LANES-1:0]     rej, full_lanes;
   logic                               full, acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign do_set_in  = (req_tuser == ssc_pkg::KIND_SAMPLE) && (side_ff < pps_ff);
   // result register must be free before the decision is committed
   assign fire       = (state_ff == ST_DECIDE) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      drain_in = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               addr_in  = '0;
               state_in = do_set_in ? ST_SCAN : ST_DECIDE;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == ssc_pkg::ADDR_W'(ssc_pkg::STORE_DEPTH - 1)) begin
               drain_in = ssc_pkg::DRAIN_W'(ssc_pkg::DRAIN_CYCLES - 1);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            if (drain_ff == '0) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // merge what the lanes found
   always_comb begin
      rej        = '0;
      full_lanes = '0;
      for (int l = 0; l < ssc_pkg::LANES; l++) begin
         rej[l]        = lane_stat[l].reject;
         full_lanes[l] = (lane_stat[l].fill == ssc_pkg::FILL_W'(ssc_pkg::STORE_DEPTH));
      end
      full = do_set_ff & (|(full_lanes[ssc_pkg::LANES-1:0] & pres_ff));
      acc  = do_set_ff & ~full & (rej == '0);
   end

   always_comb begin
      side_in = side_ff;
      if (fire) begin
         if ((kind_ff == ssc_pkg::KIND_SIDE) || (kind_ff == ssc_pkg::KIND_CLEAR)) begin
            side_in = '0;
         end else if (acc) begin
            side_in = side_ff + 1'b1;
         end
      end
   end

   always_comb begin
      logic [ssc_pkg::FILL_W-1:0] cnt;
      rsp_data_in = '0;
      rsp_data_in[ssc_pkg::RSP_ACC_BIT] = acc;
      rsp_data_in[ssc_pkg::RSP_REJ_LSB +: ssc_pkg::PORT_LANES] = do_set_ff ? rej : '0;
      rsp_data_in[ssc_pkg::RSP_FULL_BIT] = full;
      rsp_data_in[ssc_pkg::RSP_SIDE_LSB +: ssc_pkg::FILL_W] = side_in;
      rsp_data_in[ssc_pkg::RSP_DONE_BIT] = ({1'b0, side_in} >= {1'b0, pps_ff});
      for (int l = 0; l < ssc_pkg::LANES; l++) begin
         cnt = lane_stat[l].fill;
         if (kind_ff == ssc_pkg::KIND_CLEAR) begin
            cnt = '0;
         end else if (acc && pres_ff[l]) begin
            cnt = lane_stat[l].fill + 1'b1;
         end
         rsp_data_in[ssc_pkg::RSP_COUNT_LSB + l*ssc_pkg::FILL_W +: ssc_pkg::FILL_W] = cnt;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // capture the item; payload needs no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff   <= req_tuser;
         do_set_ff <= do_set_in;
         upd_ff    <= req_tdata[ssc_pkg::REQ_UPD_LSB +: ssc_pkg::LANES];
         pres_ff   <= req_tdata[ssc_pkg::REQ_PRES_LSB +: ssc_pkg::LANES];
         for (int l = 0; l < ssc_pkg::LANES; l++) begin
            vec_ff[l] <= req_tdata[l*ssc_pkg::VEC_W +: ssc_pkg::VEC_W];
         end
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
      addr_ff  <= addr_in;
      drain_ff <= drain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         min_dist_ff  <= ssc_pkg::MIN_DIST_RESET;
         pps_ff       <= ssc_pkg::PPS_RESET;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && (csr_index == ssc_pkg::CSR_MIN_DIST)) begin
            min_dist_ff <= csr_data;
         end
         if (csr_valid && (csr_index == ssc_pkg::CSR_PPS)) begin
            pps_ff <= csr_data[ssc_pkg::PPS_W-1:0];
         end
      end
   end

   assign cmd.start     = req_xfer;
   assign cmd.scan_vld  = (state_ff == ST_SCAN);
   assign cmd.scan_addr = addr_ff;
   assign cmd.commit    = fire & acc;
   assign cmd.clear     = fire & (kind_ff == ssc_pkg::KIND_CLEAR);

   assign lane_vec   = vec_ff;
   assign lane_upd   = upd_ff;
   assign lane_pres  = pres_ff;
   assign min_dist   = min_dist_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hw/rtl/spaced_sample_collector.sv -----
// Top level of the spaced sample collector: control and merge stage plus one lane per sensor.
// Depends on ssc_pkg, ssc_lane and ssc_ctrl.

// After its transfer a sample set (kind 0) is scanned: every lane walks all 256 entries of
// its own store in parallel, one entry per cycle through its single read port; then the
// compare pipeline drains, and the decide step appends an accepted set and loads the result
// (it waits while the previous result still waits to transfer). A set that arrives after
// the side is complete, a new side, a clear or an unused kind goes straight to the decide
// step. One item is in work at a time; a new item is taken as soon as the previous
// result sits in the result register, even if it has not yet been transferred. Store contents
// are not cleared: a lane only compares entries below its fill count.

module spaced_sample_collector (
   input  logic                            clock,
   input  logic                            reset,
   // tdata: lane0_vector, lane1_vector, lane2_vector, lane3_vector, updated_mask, present_mask
   input  logic [ssc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: kind
   input  logic [ssc_pkg::KIND_W-1:0]      req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: accepted, reject_lanes, store_full, side_count, side_done,
   //        lane0_count, lane1_count, lane2_count, lane3_count, zero fill
   output logic [ssc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssc_pkg::DIST_W-1:0]      csr_data
);

   ssc_pkg::lane_cmd_type          cmd;
   ssc_pkg::vec_type               lane_vec  [ssc_pkg::LANES];
   ssc_pkg::lane_stat_type         lane_stat [ssc_pkg::LANES];
   logic [ssc_pkg::LANES-1:0]      lane_upd, lane_pres;
   logic [ssc_pkg::DIST_W-1:0]     min_dist;

   ssc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .lane_vec   (lane_vec),
      .lane_upd   (lane_upd),
      .lane_pres  (lane_pres),
      .min_dist   (min_dist),
      .lane_stat  (lane_stat)
   );

   for (genvar l = 0; l < ssc_pkg::LANES; l++) begin : g_lane
      ssc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .vec      (lane_vec[l]),
         .upd      (lane_upd[l]),
         .pres     (lane_pres[l]),
         .min_dist (min_dist),
         .stat     (lane_stat[l])
      );
   end

endmodule

// ----- hw/rtl/ssc_checker.sv -----
// Port-level checks for the spaced sample collector, bound to the top level.
// Depends on ssc_pkg.

module ssc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ssc_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // an accepted set carries neither a spacing reject nor a full store
   a_accept_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[ssc_pkg::RSP_ACC_BIT] |->
         rsp_tdata[ssc_pkg::RSP_REJ_LSB +: ssc_pkg::PORT_LANES] == '0 &&
         !rsp_tdata[ssc_pkg::RSP_FULL_BIT])
      else $error("accepted set also flagged as rejected");

   a_accept_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[ssc_pkg::RSP_ACC_BIT] |->
         rsp_tdata[ssc_pkg::RSP_SIDE_LSB +: ssc_pkg::FILL_W] != '0)
      else $error("accepted set left side count at zero");

   // a new item is never taken in the cycle right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

endmodule

bind spaced_sample_collector ssc_checker u_ssc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/testbench.sv -----
// Stream testbench for the spaced sample collector: queued driver, result monitor and an
// in-bench predictor of spacing rejects, store fill and side counts.
// Depends on ssc_pkg and spaced_sample_collector.

module testbench;
   import ssc_pkg::*;

   localparam logic [KIND_W-1:0]    KIND_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam int SET_CYCLES  = 261;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int HOLD_CYCLES = 3000;
   localparam int HIST_DEPTH  = 32;

   typedef struct packed {
      logic [KIND_W-1:0]                 kind;
      logic [PORT_LANES-1:0]             pres;
      logic [PORT_LANES-1:0]             upd;
      logic [PORT_LANES-1:0][VEC_W-1:0]  vec;
   } sample_set_type;

   typedef struct packed {
      logic                               accepted;
      logic [PORT_LANES-1:0]              reject_lanes;
      logic                               store_full;
      logic [FILL_W-1:0]                  side_count;
      logic                               side_done;
      logic [PORT_LANES-1:0][FILL_W-1:0]  lane_count;
   } outcome_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_W-1:0]     req_tuser  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [DIST_W-1:0]     csr_data   = '0;

   // predictor state
   logic [VEC_W-1:0]  stored_pts [LANES][STORE_DEPTH];
   logic [FILL_W-1:0] lane_pts [LANES];
   logic [FILL_W-1:0] side_sets;
   logic [DIST_W-1:0] spacing_sq;
   logic [PPS_W-1:0]  side_target;

   // stimulus state
   sample_set_type   set_q[$];
   outcome_type      outcome_q[$];
   sample_set_type   on_bus;
   logic [VEC_W-1:0] recent_vec [LANES][HIST_DEPTH];
   int               recent_cnt [LANES];
   int unsigned      req_sent_n  = 0;
   int unsigned      req_taken_n = 0;
   int unsigned      tx_idle_pct = 0;
   int unsigned      rx_idle_pct = 0;
   int unsigned      mismatches  = 0;
   int unsigned      cycle_n     = 0;
   int unsigned      hold_left   = 0;
   logic             hold_request = 1'b0;
   logic             hold_served  = 1'b0;

   spaced_sample_collector i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int axis_signed(input logic [VEC_W-1:0] v, input int axis);
      logic [SLOT_W-1:0] slot;
      int val;
      slot = v[axis*SLOT_W +: SLOT_W];
      val = int'(slot[SAMPLE_BITS-1:0]);
      if (slot[SAMPLE_BITS-1]) val -= 1 << SAMPLE_BITS;
      return val;
   endfunction

   function automatic longint unsigned span_sq(input logic [VEC_W-1:0] a,
                                               input logic [VEC_W-1:0] b);
      longint unsigned sum;
      longint d;
      sum = 0;
      for (int ax = 0; ax < AXES; ax++) begin
         d = longint'(axis_signed(a, ax)) - longint'(axis_signed(b, ax));
         sum += d * d;
      end
      return sum;
   endfunction

   function automatic outcome_type predict_collect(input sample_set_type s);
      outcome_type o;
      o = '0;
      case (s.kind)
         KIND_SIDE: side_sets = '0;
         KIND_CLEAR: begin
            for (int l = 0; l < LANES; l++) lane_pts[l] = '0;
            side_sets = '0;
         end
         KIND_SAMPLE: begin
            if (side_sets < side_target) begin
               for (int l = 0; l < LANES; l++) begin
                  if (s.pres[l] && lane_pts[l] >= STORE_DEPTH) o.store_full = 1'b1;
                  if (s.upd[l]) begin
                     for (int i = 0; i < int'(lane_pts[l]) && i < STORE_DEPTH; i++) begin
                        if (span_sq(s.vec[l], stored_pts[l][i]) < spacing_sq) begin
                           o.reject_lanes[l] = 1'b1;
                           break;
                        end
                     end
                  end
               end
               if (o.reject_lanes == '0 && !o.store_full) begin
                  for (int l = 0; l < LANES; l++) begin
                     if (s.pres[l]) begin
                        // a present lane without a fresh sample appends zero
                        stored_pts[l][lane_pts[l][ADDR_W-1:0]] = s.upd[l] ? s.vec[l] : '0;
                        lane_pts[l] = lane_pts[l] + 1'b1;
                     end
                  end
                  side_sets = side_sets + 1'b1;
                  o.accepted = 1'b1;
               end
            end
         end
         default: ;
      endcase
      o.side_count = side_sets;
      o.side_done  = side_sets >= side_target;
      for (int l = 0; l < PORT_LANES; l++) o.lane_count[l] = (l < LANES) ? lane_pts[l] : '0;
      return o;
   endfunction

   function automatic logic [VEC_W-1:0] xyz(input logic [SLOT_W-1:0] x,
                                            input logic [SLOT_W-1:0] y,
                                            input logic [SLOT_W-1:0] z);
      return {z, y, x};
   endfunction

   function automatic logic [VEC_W-1:0] rand_vec();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[VEC_W-1:0];
   endfunction

   // a point within span of a recently offered vector of this lane
   function automatic logic [VEC_W-1:0] near_vec(input int lane, input int span);
      logic [VEC_W-1:0] v;
      int n;
      n = recent_cnt[lane] < HIST_DEPTH ? recent_cnt[lane] : HIST_DEPTH;
      if (n == 0) return rand_vec();
      v = recent_vec[lane][$urandom_range(n - 1)];
      for (int ax = 0; ax < AXES; ax++)
         v[ax*SLOT_W +: SLOT_W] = v[ax*SLOT_W +: SLOT_W]
                                  + SLOT_W'(int'($urandom_range(2 * span)) - span);
      return v;
   endfunction

   function automatic sample_set_type mk_set(input logic [KIND_W-1:0] kind,
                                             input logic [VEC_W-1:0] v0,
                                             input logic [VEC_W-1:0] v1,
                                             input logic [VEC_W-1:0] v2,
                                             input logic [VEC_W-1:0] v3,
                                             input logic [PORT_LANES-1:0] upd,
                                             input logic [PORT_LANES-1:0] pres);
      sample_set_type s;
      s.kind = kind;
      s.vec  = {v3, v2, v1, v0};
      s.upd  = upd;
      s.pres = pres;
      return s;
   endfunction

   task automatic queue_set(input sample_set_type s);
      for (int l = 0; l < LANES; l++) begin
         if (s.upd[l]) begin
            recent_vec[l][recent_cnt[l] % HIST_DEPTH] = s.vec[l];
            recent_cnt[l]++;
         end
      end
      set_q.push_back(s);
   endtask

   task automatic queue_random_sets(input int count, input int span);
      sample_set_type s;
      int unsigned roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         s.kind = roll < 88 ? KIND_SAMPLE : roll < 93 ? KIND_SIDE :
                  roll < 97 ? KIND_CLEAR : KIND_SPARE;
         for (int l = 0; l < PORT_LANES; l++)
            s.vec[l] = $urandom_range(1) ? near_vec(l, span) : rand_vec();
         s.upd  = $urandom_range(2) != 0 ? 4'hF : 4'($urandom_range(15));
         s.pres = $urandom_range(2) != 0 ? 4'hF : 4'($urandom_range(15));
         queue_set(s);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MIN_DIST) spacing_sq = val;
      else if (idx == CSR_PPS) side_target = val[PPS_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every queued item has been sent, taken and answered
   task automatic wait_drained();
      do @(negedge clock);
      while (set_q.size() != 0 || req_tvalid || req_sent_n != req_taken_n ||
             outcome_q.size() != 0);
   endtask

   task automatic check_field(input string what, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // driver: hold each item until its transfer, then offer the next or idle
   always @(negedge clock) begin
      if (!req_tvalid || req_taken_n == req_sent_n) begin
         if (!reset && set_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            on_bus = set_q.pop_front();
            req_sent_n++;
            req_tdata  <= {on_bus.pres, on_bus.upd, on_bus.vec};
            req_tuser  <= on_bus.kind;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random idling, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_served) begin
         hold_served = 1'b1;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= rx_idle_pct;
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && req_tvalid && req_tready) begin
         outcome_q.push_back(predict_collect(on_bus));
         req_taken_n++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.accepted     = rsp_tdata[RSP_ACC_BIT];
         got.reject_lanes = rsp_tdata[RSP_REJ_LSB +: PORT_LANES];
         got.store_full   = rsp_tdata[RSP_FULL_BIT];
         got.side_count   = rsp_tdata[RSP_SIDE_LSB +: FILL_W];
         got.side_done    = rsp_tdata[RSP_DONE_BIT];
         for (int l = 0; l < PORT_LANES; l++)
            got.lane_count[l] = rsp_tdata[RSP_COUNT_LSB + l*FILL_W +: FILL_W];
         if (outcome_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
         end else begin
            want = outcome_q.pop_front();
            check_field("accepted", want.accepted, got.accepted);
            check_field("reject_lanes", want.reject_lanes, got.reject_lanes);
            check_field("store_full", want.store_full, got.store_full);
            check_field("side_count", want.side_count, got.side_count);
            check_field("side_done", want.side_done, got.side_done);
            for (int l = 0; l < PORT_LANES; l++)
               check_field($sformatf("lane%0d_count", l), want.lane_count[l],
                           got.lane_count[l]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_n++;
      if (cycle_n > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      for (int l = 0; l < LANES; l++) begin
         lane_pts[l]   = '0;
         recent_cnt[l] = 0;
      end
      side_sets   = '0;
      spacing_sq  = MIN_DIST_RESET;
      side_target = PPS_RESET;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed sets at reset settings
      tx_idle_pct = 20;
      rx_idle_pct = 63;
      queue_set(mk_set(KIND_SAMPLE, xyz(16'h0000, 16'h0000, 16'h0000),
                       xyz(16'hFFFF, 16'hFFFF, 16'hFFFF), xyz(16'h7FFF, 16'h7FFF, 16'h7FFF),
                       xyz(16'h8000, 16'h8000, 16'h8000), 4'hF, 4'hF));
      queue_set(mk_set(KIND_SAMPLE, xyz(16'h0000, 16'h0000, 16'h0000),
                       xyz(16'hFFFF, 16'hFFFF, 16'hFFFF), xyz(16'h7FFF, 16'h7FFF, 16'h7FFF),
                       xyz(16'h8000, 16'h8000, 16'h8000), 4'hF, 4'hF));
      // spacing boundary: 99 squared is too close, 100 squared is not
      queue_set(mk_set(KIND_SAMPLE, xyz(16'd99, 16'd0, 16'd0), '0, '0, '0, 4'h1, 4'h1));
      queue_set(mk_set(KIND_SAMPLE, xyz(16'd100, 16'd0, 16'd0), '0, '0, '0, 4'h1, 4'h1));
      queue_set(mk_set(KIND_SAMPLE, '0, '0, xyz(16'h8000, 16'h8000, 16'h8000), '0,
                       4'h4, 4'h4));
      // updated lanes that are not present still compare
      queue_set(mk_set(KIND_SAMPLE, '0, xyz(16'd0, 16'd0, 16'd0), '0, '0, 4'h2, 4'h0));
      queue_set(mk_set(KIND_SAMPLE, '0, xyz(16'd1000, 16'd1000, 16'd1000), '0, '0,
                       4'h2, 4'h0));
      // present without a fresh sample appends zero, then a point near zero collides
      queue_set(mk_set(KIND_SAMPLE, '0, '0, '0, '0, 4'h0, 4'h8));
      queue_set(mk_set(KIND_SAMPLE, '0, '0, '0, xyz(16'd5, 16'd5, 16'd5), 4'h8, 4'h8));
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'h0, 4'h0));
      queue_set(mk_set(KIND_SPARE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_SIDE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_CLEAR, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_SAMPLE, xyz(16'h0000, 16'h0000, 16'h0000),
                       xyz(16'hFFFF, 16'hFFFF, 16'hFFFF), xyz(16'h7FFF, 16'h7FFF, 16'h7FFF),
                       xyz(16'h8000, 16'h8000, 16'h8000), 4'hF, 4'hF));
      wait_drained();

      // unused indexes leave the settings alone; one set per side completes at once
      write_csr(CSR_SPARE_LO, $urandom());
      write_csr(CSR_SPARE_HI, $urandom());
      write_csr(CSR_PPS, 32'd1);
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_SIDE, '0, '0, '0, '0, 4'h0, 4'h0));
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_SPARE, '0, '0, '0, '0, 4'h0, 4'h0));
      wait_drained();

      // fill every store to the limit with spacing off, then run into the full stores
      write_csr(CSR_MIN_DIST, 32'd0);
      write_csr(CSR_PPS, 32'(STORE_DEPTH));
      queue_set(mk_set(KIND_CLEAR, '0, '0, '0, '0, 4'h0, 4'h0));
      for (int n = 0; n < STORE_DEPTH; n++)
         queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                          4'($urandom_range(15)), 4'hF));
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_SIDE, '0, '0, '0, '0, 4'h0, 4'h0));
      for (int n = 0; n < 6; n++)
         queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                          4'($urandom_range(15)), 4'($urandom_range(1, 15))));
      wait_drained();
      write_csr(CSR_MIN_DIST, '1);
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'h0));
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'h0, 4'h0));
      queue_set(mk_set(KIND_CLEAR, '0, '0, '0, '0, 4'h0, 4'h0));
      queue_set(mk_set(KIND_SAMPLE, rand_vec(), rand_vec(), rand_vec(), rand_vec(),
                       4'hF, 4'hF));
      wait_drained();

      write_csr(CSR_MIN_DIST, 32'($urandom_range(2000, 40000)));
      write_csr(CSR_PPS, 32'($urandom_range(20, 60)));
      queue_random_sets(230, 200);
      wait_drained();

      tx_idle_pct = 63;
      rx_idle_pct = 20;
      write_csr(CSR_MIN_DIST, $urandom());
      write_csr(CSR_PPS, 32'($urandom_range(1, 256)));
      queue_random_sets(230, 30000);
      wait_drained();

      // no idling; the receiver holds off once so the input side backs up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_csr(CSR_MIN_DIST, 32'($urandom_range(0, 20000)));
      write_csr(CSR_PPS, 32'($urandom_range(1, 256)));
      queue_random_sets(230, 150);
      hold_request = 1'b1;
      wait_drained();

      repeat (SET_CYCLES + 40) @(posedge clock);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
